// ===== design/ptrbq_pkg.sv =====
// Shared types and constants for the process table with ready and blocked queues.
package ptrbq_pkg;

    localparam int DefTableEntries = 16;
    localparam int MaxResults      = 16;
    localparam int ResW            = $clog2(MaxResults + 1);

    // Command codes.
    typedef enum logic [3:0] {
        CMD_CREATE     = 4'd0,
        CMD_DELETE     = 4'd1,
        CMD_BLOCK      = 4'd2,
        CMD_UNBLOCK    = 4'd3,
        CMD_SUSPEND    = 4'd4,
        CMD_RESUME     = 4'd5,
        CMD_SET_PRIO   = 4'd6,
        CMD_SHOW       = 4'd7,
        CMD_LIST_READY = 4'd8,
        CMD_LIST_BLK   = 4'd9,
        CMD_LIST_ALL   = 4'd10
    } t_cmd;

    // Status codes.
    typedef enum logic [3:0] {
        ST_OK                = 4'd0,
        ST_NOT_FOUND         = 4'd1,
        ST_DUPLICATE         = 4'd2,
        ST_BAD_PRIORITY      = 4'd3,
        ST_ALREADY_BLOCKED   = 4'd4,
        ST_NOT_BLOCKED       = 4'd5,
        ST_ALREADY_SUSPENDED = 4'd6,
        ST_NOT_SUSPENDED     = 4'd7,
        ST_FULL              = 4'd8,
        ST_BAD_COMMAND       = 4'd9,
        ST_LIST_EMPTY        = 4'd10
    } t_status;

    // One process record as held in the record memory.
    typedef struct packed {
        logic [31:0]       key;
        logic signed [7:0] prio;
        logic              sys;
        logic              blk;
        logic              sus;
    } t_rec;

endpackage

// ===== design/ptrbq_ram.sv =====
// Generic single-write, single-read memory with registered read data.
module ptrbq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port; read data holds between reads.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/process_table_ready_blocked_queues.sv =====
// Top level of the process table with ready and blocked FIFO queues.
//
// Input channel (i_in_valid / o_in_ready) carries one command with its
// process id, requested priority and class. Output channel (o_out_valid /
// i_out_ready) returns one result per transfer; o_last marks the final one.
// A command is taken only while the sequencer is idle. Keyed commands first
// sweep the record memory once, one slot per cycle. They then decide, update
// the record and link memories and load the result. Listings need no sweep:
// each listed entry takes one memory read and then one result load, at most
// 16 results per command. The record memory and the two link memories each
// have one read port. A result is held in the output register until taken;
// a stalled receiver holds the sequencer in its result state, and a new
// command may be taken while the last result still waits. Reset empties the
// table and both queues at once; no clearing pass is needed.
module process_table_ready_blocked_queues
    import ptrbq_pkg::*;
#(
    parameter int TABLE_ENTRIES = DefTableEntries
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [3:0]        i_command,
    input  logic [31:0]       i_process_id,
    input  logic signed [8:0] i_priority_req,
    input  logic              i_is_system,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [3:0]        o_status,
    output logic [31:0]       o_entry_id,
    output logic signed [7:0] o_entry_priority,
    output logic              o_entry_system,
    output logic [1:0]        o_entry_state,
    output logic              o_entry_suspended,
    output logic              o_last
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [AW-1:0] LastSlot = AW'(TABLE_ENTRIES - 1);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_SCAN   = 9'b000000010,
        S_DECIDE = 9'b000000100,
        S_LNK_RD = 9'b000001000,
        S_UNLINK = 9'b000010000,
        S_APPEND = 9'b000100000,
        S_EMIT   = 9'b001000000,
        S_L_RD   = 9'b010000000,
        S_L_EMIT = 9'b100000000
    } t_state;

    t_state r_state;

    // Latched command.
    t_cmd              r_cmd;
    logic [31:0]       r_key;
    logic signed [8:0] r_prio;
    logic              r_sys;

    // Table and queue control.
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [AW-1:0] r_rdy_head, r_rdy_tail, r_blk_head, r_blk_tail;
    logic [CW-1:0] r_rdy_cnt, r_blk_cnt;

    // Sweep and work registers.
    logic [AW-1:0] r_idx, r_chk, r_slot, r_free, r_cur;
    logic          r_iss_done, r_chk_v, r_found, r_free_ok, r_tgt, r_show, r_phase;
    logic [CW-1:0] r_left;
    logic [ResW-1:0] r_nres;
    t_rec          r_rec;
    t_status       r_status;

    // Output register.
    logic r_o_valid;
    t_rec r_o_rec;
    logic [3:0] r_o_status;
    logic r_o_last;

    // Memory ports.
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    t_rec          rec_rdata;
    logic [AW-1:0] fwd_rdata, back_rdata;
    logic          rec_we, fwd_we, back_we;
    logic [AW-1:0] rec_waddr, fwd_waddr, back_waddr, fwd_wdata, back_wdata;
    t_rec          rec_wdata;

    logic prio_ok, out_free, out_load, old_blk, lst_last;
    logic [AW-1:0] cur_head, cur_tail, app_tail;
    logic [CW-1:0] cur_cnt, app_cnt;

    assign prio_ok  = (r_prio >= -9'sd127) && (r_prio <= 9'sd127);
    assign out_free = !r_o_valid || i_out_ready;
    assign out_load = out_free && ((r_state == S_EMIT) || (r_state == S_L_EMIT));
    assign old_blk  = r_rec.blk;
    assign cur_head = old_blk ? r_blk_head : r_rdy_head;
    assign cur_tail = old_blk ? r_blk_tail : r_rdy_tail;
    assign cur_cnt  = old_blk ? r_blk_cnt : r_rdy_cnt;
    assign app_tail = r_tgt ? r_blk_tail : r_rdy_tail;
    assign app_cnt  = r_tgt ? r_blk_cnt : r_rdy_cnt;

    // Final result of a listing: result limit, or end of the last list walked.
    assign lst_last = (r_nres == ResW'(MaxResults - 1)) ||
                      ((r_left == CW'(1)) &&
                       !(!r_phase && (r_cmd == CMD_LIST_ALL) && (r_blk_cnt != '0)));

    // Key compare of the swept slot.
    function automatic logic rec_data_key_match(input logic [31:0] a, input logic [31:0] b);
        rec_data_key_match = (a == b);
    endfunction

    // Memory read and write control.
    always_comb begin
        rd_en      = 1'b0;
        rd_addr    = r_idx;
        rec_we     = 1'b0;
        rec_waddr  = r_slot;
        rec_wdata  = r_rec;
        fwd_we     = 1'b0;
        fwd_waddr  = back_rdata;
        fwd_wdata  = fwd_rdata;
        back_we    = 1'b0;
        back_waddr = fwd_rdata;
        back_wdata = back_rdata;
        unique case (r_state)
            S_SCAN: begin
                rd_en   = !r_iss_done;
                rd_addr = r_idx;
            end
            S_LNK_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_slot;
            end
            S_L_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_cur;
            end
            S_DECIDE: begin
                unique case (r_cmd)
                    CMD_CREATE: begin
                        rec_we    = !r_found && prio_ok && r_free_ok;
                        rec_waddr = r_free;
                        rec_wdata = '{key: r_key, prio: r_prio[7:0], sys: r_sys,
                                      blk: 1'b0, sus: 1'b0};
                    end
                    CMD_BLOCK: begin
                        rec_we        = r_found && !r_rec.blk;
                        rec_wdata.blk = 1'b1;
                    end
                    CMD_UNBLOCK: begin
                        rec_we        = r_found && r_rec.blk;
                        rec_wdata.blk = 1'b0;
                    end
                    CMD_SUSPEND: begin
                        rec_we        = r_found && !r_rec.sus;
                        rec_wdata.sus = 1'b1;
                    end
                    CMD_RESUME: begin
                        rec_we        = r_found && r_rec.sus;
                        rec_wdata.sus = 1'b0;
                    end
                    CMD_SET_PRIO: begin
                        rec_we         = r_found && prio_ok;
                        rec_wdata.prio = r_prio[7:0];
                    end
                    default: begin
                        rec_we = 1'b0;
                    end
                endcase
            end
            S_UNLINK: begin
                // Middle entry: bridge its neighbors.
                if (cur_cnt > CW'(1) && r_slot != cur_head && r_slot != cur_tail) begin
                    fwd_we  = 1'b1;
                    back_we = 1'b1;
                end
            end
            S_APPEND: begin
                if (app_cnt != '0) begin
                    fwd_we     = 1'b1;
                    fwd_waddr  = app_tail;
                    fwd_wdata  = r_slot;
                    back_we    = 1'b1;
                    back_waddr = r_slot;
                    back_wdata = app_tail;
                end
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    ptrbq_ram #(.WIDTH($bits(t_rec)), .DEPTH(TABLE_ENTRIES)) u_rec_ram (
        .i_clk   (i_clk),
        .i_we    (rec_we),
        .i_waddr (rec_waddr),
        .i_wdata (rec_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rec_rdata)
    );

    ptrbq_ram #(.WIDTH(AW), .DEPTH(TABLE_ENTRIES)) u_fwd_ram (
        .i_clk   (i_clk),
        .i_we    (fwd_we),
        .i_waddr (fwd_waddr),
        .i_wdata (fwd_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (fwd_rdata)
    );

    ptrbq_ram #(.WIDTH(AW), .DEPTH(TABLE_ENTRIES)) u_back_ram (
        .i_clk   (i_clk),
        .i_we    (back_we),
        .i_waddr (back_waddr),
        .i_wdata (back_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (back_rdata)
    );

    // Command sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_valid    <= '0;
            r_rdy_head <= '0;
            r_rdy_tail <= '0;
            r_rdy_cnt  <= '0;
            r_blk_head <= '0;
            r_blk_tail <= '0;
            r_blk_cnt  <= '0;
            r_o_valid  <= 1'b0;
            r_chk_v    <= 1'b0;
        end else begin
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && i_out_ready) begin
                r_o_valid <= 1'b0;
            end
            r_chk_v <= (r_state == S_SCAN) && rd_en;
            r_chk   <= r_idx;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd      <= t_cmd'(i_command);
                        r_key      <= i_process_id;
                        r_prio     <= i_priority_req;
                        r_sys      <= i_is_system;
                        r_show     <= 1'b0;
                        r_nres     <= '0;
                        r_idx      <= '0;
                        r_iss_done <= 1'b0;
                        r_found    <= 1'b0;
                        r_free_ok  <= 1'b0;
                        if (i_command > CMD_LIST_ALL) begin
                            r_status <= ST_BAD_COMMAND;
                            r_state  <= S_EMIT;
                        end else if (i_command >= CMD_LIST_READY) begin
                            if (i_command != CMD_LIST_BLK && r_rdy_cnt != '0) begin
                                r_cur   <= r_rdy_head;
                                r_left  <= r_rdy_cnt;
                                r_phase <= 1'b0;
                                r_state <= S_L_RD;
                            end else if (i_command != CMD_LIST_READY && r_blk_cnt != '0) begin
                                r_cur   <= r_blk_head;
                                r_left  <= r_blk_cnt;
                                r_phase <= 1'b1;
                                r_state <= S_L_RD;
                            end else begin
                                r_status <= ST_LIST_EMPTY;
                                r_state  <= S_EMIT;
                            end
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // Issue one slot read a cycle, check the previous one.
                    if (!r_iss_done) begin
                        if (r_idx == LastSlot) begin
                            r_iss_done <= 1'b1;
                        end else begin
                            r_idx <= r_idx + AW'(1);
                        end
                    end
                    if (r_chk_v) begin
                        if (r_valid[r_chk] && rec_data_key_match(rec_rdata.key, r_key)) begin
                            r_found <= 1'b1;
                            r_slot  <= r_chk;
                            r_rec   <= rec_rdata;
                        end
                        if (!r_valid[r_chk] && !r_free_ok) begin
                            r_free_ok <= 1'b1;
                            r_free    <= r_chk;
                        end
                        if (r_chk == LastSlot) begin
                            r_state <= S_DECIDE;
                        end
                    end
                end
                S_DECIDE: begin
                    if (r_cmd == CMD_CREATE) begin
                        if (r_found) begin
                            r_status <= ST_DUPLICATE;
                            r_state  <= S_EMIT;
                        end else if (!prio_ok) begin
                            r_status <= ST_BAD_PRIORITY;
                            r_state  <= S_EMIT;
                        end else if (!r_free_ok) begin
                            r_status <= ST_FULL;
                            r_state  <= S_EMIT;
                        end else begin
                            r_status        <= ST_OK;
                            r_valid[r_free] <= 1'b1;
                            r_slot          <= r_free;
                            r_tgt           <= 1'b0;
                            r_state         <= S_APPEND;
                        end
                    end else if (!r_found) begin
                        r_status <= ST_NOT_FOUND;
                        r_state  <= S_EMIT;
                    end else begin
                        unique case (r_cmd)
                            CMD_DELETE: begin
                                r_status <= ST_OK;
                                r_state  <= S_LNK_RD;
                            end
                            CMD_BLOCK: begin
                                if (r_rec.blk) begin
                                    r_status <= ST_ALREADY_BLOCKED;
                                    r_state  <= S_EMIT;
                                end else begin
                                    r_status <= ST_OK;
                                    r_tgt    <= 1'b1;
                                    r_state  <= S_LNK_RD;
                                end
                            end
                            CMD_UNBLOCK: begin
                                if (!r_rec.blk) begin
                                    r_status <= ST_NOT_BLOCKED;
                                    r_state  <= S_EMIT;
                                end else begin
                                    r_status <= ST_OK;
                                    r_tgt    <= 1'b0;
                                    r_state  <= S_LNK_RD;
                                end
                            end
                            CMD_SUSPEND: begin
                                r_status <= r_rec.sus ? ST_ALREADY_SUSPENDED : ST_OK;
                                r_state  <= S_EMIT;
                            end
                            CMD_RESUME: begin
                                r_status <= !r_rec.sus ? ST_NOT_SUSPENDED : ST_OK;
                                r_state  <= S_EMIT;
                            end
                            CMD_SET_PRIO: begin
                                r_status <= !prio_ok ? ST_BAD_PRIORITY : ST_OK;
                                r_state  <= S_EMIT;
                            end
                            default: begin
                                r_status <= ST_OK;
                                r_show   <= 1'b1;
                                r_state  <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_LNK_RD: begin
                    r_state <= S_UNLINK;
                end
                S_UNLINK: begin
                    // Remove the slot from the list it sits on now.
                    if (cur_cnt != '0) begin
                        if (cur_cnt == CW'(1)) begin
                            if (old_blk) r_blk_cnt <= '0;
                            else         r_rdy_cnt <= '0;
                        end else begin
                            if (r_slot == cur_head) begin
                                if (old_blk) r_blk_head <= fwd_rdata;
                                else         r_rdy_head <= fwd_rdata;
                            end else if (r_slot == cur_tail) begin
                                if (old_blk) r_blk_tail <= back_rdata;
                                else         r_rdy_tail <= back_rdata;
                            end
                            if (old_blk) r_blk_cnt <= r_blk_cnt - CW'(1);
                            else         r_rdy_cnt <= r_rdy_cnt - CW'(1);
                        end
                    end
                    if (r_cmd == CMD_DELETE) begin
                        r_valid[r_slot] <= 1'b0;
                        r_state         <= S_EMIT;
                    end else begin
                        r_state <= S_APPEND;
                    end
                end
                S_APPEND: begin
                    // Join the tail of the target list.
                    if (r_tgt) begin
                        if (r_blk_cnt == '0) r_blk_head <= r_slot;
                        r_blk_tail <= r_slot;
                        r_blk_cnt  <= r_blk_cnt + CW'(1);
                    end else begin
                        if (r_rdy_cnt == '0) r_rdy_head <= r_slot;
                        r_rdy_tail <= r_slot;
                        r_rdy_cnt  <= r_rdy_cnt + CW'(1);
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_o_status <= r_status;
                        r_o_rec    <= r_show ? r_rec : '0;
                        r_o_last   <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                S_L_RD: begin
                    r_state <= S_L_EMIT;
                end
                S_L_EMIT: begin
                    if (out_free) begin
                        r_o_status <= ST_OK;
                        r_o_rec    <= rec_rdata;
                        r_o_last   <= lst_last;
                        r_nres     <= r_nres + ResW'(1);
                        if (lst_last) begin
                            r_state <= S_IDLE;
                        end else if (r_left == CW'(1)) begin
                            r_cur   <= r_blk_head;
                            r_left  <= r_blk_cnt;
                            r_phase <= 1'b1;
                            r_state <= S_L_RD;
                        end else begin
                            r_cur   <= fwd_rdata;
                            r_left  <= r_left - CW'(1);
                            r_state <= S_L_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Ports.
    assign o_in_ready        = (r_state == S_IDLE);
    assign o_out_valid       = r_o_valid;
    assign o_status          = r_o_status;
    assign o_entry_id        = r_o_rec.key;
    assign o_entry_priority  = r_o_rec.prio;
    assign o_entry_system    = r_o_rec.sys;
    assign o_entry_state     = {r_o_rec.blk, 1'b0};
    assign o_entry_suspended = r_o_rec.sus;
    assign o_last            = r_o_last;

endmodule
